### sv/msw_pkg.sv
// Shared types and codes for the multi-channel stopwatch bank.
package msw_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned ChanW = 5;
  localparam int unsigned OpW   = 3;

  typedef enum logic [OpW-1:0] {
    OP_START         = 3'd0,
    OP_PAUSE         = 3'd1,
    OP_PAUSE_RESTART = 3'd2,
    OP_RESET_ONE     = 3'd3,
    OP_RESET_ALL     = 3'd4,
    OP_QUERY         = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [ChanW-1:0] channel;
    logic [TimeW-1:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [TimeW-1:0] returned_time;
    logic [TimeW-1:0] last_interval;
    logic [TimeW-1:0] total_time;
    logic             channel_valid;
  } out_t;

  typedef struct packed {
    logic [TimeW-1:0] begin_time;
    logic [TimeW-1:0] last_span;
    logic [TimeW-1:0] accumulated_time;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic clr_all;
  } upd_t;

endpackage

### sv/msw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/msw_alu.sv
// Per-transaction update of one channel entry and the result it reports.
module msw_alu (
  input  msw_pkg::in_t    cmd_i,
  input  msw_pkg::entry_t ent_i,
  input  logic            ok_i,
  input  logic            all_i,
  output msw_pkg::entry_t nxt_o,
  output msw_pkg::upd_t   ctl_o,
  output msw_pkg::out_t   res_o
);
  import msw_pkg::*;

  always_comb begin
    nxt_o = ent_i;
    ctl_o = '0;
    res_o = '0;
    unique case (cmd_i.operation)
      OP_START: begin
        if (ok_i) begin
          nxt_o.begin_time    = cmd_i.timestamp;
          ctl_o.wr            = 1'b1;
          res_o.returned_time = cmd_i.timestamp;
        end
      end
      OP_PAUSE, OP_PAUSE_RESTART: begin
        if (ok_i) begin
          nxt_o.last_span        = cmd_i.timestamp - ent_i.begin_time;
          nxt_o.accumulated_time = ent_i.accumulated_time + cmd_i.timestamp
                                   - ent_i.begin_time;
          if (cmd_i.operation == OP_PAUSE_RESTART) begin
            nxt_o.begin_time = cmd_i.timestamp;
          end
          ctl_o.wr            = 1'b1;
          res_o.returned_time = cmd_i.timestamp;
        end
      end
      OP_RESET_ONE: begin
        if (ok_i) begin
          nxt_o    = '{begin_time: cmd_i.timestamp, last_span: '0, accumulated_time: '0};
          ctl_o.wr = 1'b1;
        end else if (all_i) begin
          ctl_o.clr_all = 1'b1;
        end
      end
      OP_RESET_ALL: begin
        nxt_o         = '{begin_time: cmd_i.timestamp, last_span: '0, accumulated_time: '0};
        ctl_o.clr_all = 1'b1;
      end
      default: begin
      end
    endcase
    if (ok_i) begin
      res_o.last_interval = nxt_o.last_span;
      res_o.total_time    = nxt_o.accumulated_time;
      res_o.channel_valid = 1'b1;
    end
  end

endmodule

### sv/multi_channel_stopwatch_bank.sv
// Stopwatch bank: each transaction is accepted in the idle state, which reads the channel entry
// from the state RAM; the exec state updates, writes back and loads the result register, and
// a stalled result holds it there. Reset-all does not clear the RAM: per-channel valid bits are dropped
// at once and an entry not yet rewritten reads as the clear timestamp with zero interval and total.
module multi_channel_stopwatch_bank #(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  msw_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output msw_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [msw_pkg::ChanW-1:0] cfg_data_i
);
  import msw_pkg::*;

  localparam int unsigned IdxW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CntW0 = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CmpW  = (CntW0 > ChanW) ? CntW0 : ChanW;
  localparam int unsigned EntW  = $bits(entry_t);
  localparam logic [CmpW-1:0] MaxC = CmpW'(MAX_CHANNELS);

  state_e            state_q, state_d;
  logic [ChanW-1:0]  cnt_q;
  in_t               cmd_q;
  logic              ok_q, all_q;
  logic [IdxW-1:0]   idx_q;
  logic [MAX_CHANNELS-1:0] vld_q, vld_d;
  logic [TimeW-1:0]  clr_ts_q, clr_ts_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q;

  logic              accept, exec_go;
  logic [CmpW-1:0]   ch_ext, cnt_ext, eff_cnt;
  logic              ok_d, all_d;
  logic [IdxW-1:0]   idx_d;
  logic [EntW-1:0]   rdata;
  entry_t            ent_eff, ent_nxt;
  upd_t              ctl;
  out_t              res;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ch_ext  = CmpW'(in_data_i.channel);
  assign cnt_ext = CmpW'(cnt_q);
  assign eff_cnt = (cnt_ext > MaxC) ? MaxC : cnt_ext;
  assign ok_d    = ch_ext < eff_cnt;
  assign all_d   = ch_ext == eff_cnt;
  assign idx_d   = ch_ext[IdxW-1:0];

  msw_ram #(
    .Width(EntW),
    .Depth(MAX_CHANNELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (exec_go && ctl.wr),
    .waddr_i(idx_q),
    .wdata_i(ent_nxt),
    .re_i   (accept),
    .raddr_i(idx_d),
    .rdata_o(rdata)
  );

  assign ent_eff = vld_q[idx_q] ? entry_t'(rdata)
                 : '{begin_time: clr_ts_q, last_span: '0, accumulated_time: '0};

  msw_alu u_alu (
    .cmd_i(cmd_q),
    .ent_i(ent_eff),
    .ok_i (ok_q),
    .all_i(all_q),
    .nxt_o(ent_nxt),
    .ctl_o(ctl),
    .res_o(res)
  );

  assign exec_go = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    vld_d       = vld_q;
    clr_ts_d    = clr_ts_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (ctl.wr) begin
            vld_d[idx_q] = 1'b1;
          end
          if (ctl.clr_all) begin
            vld_d    = '0;
            clr_ts_d = cmd_q.timestamp;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= ChanW'(1);
      vld_q       <= '0;
      clr_ts_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      clr_ts_q    <= clr_ts_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i;
      ok_q  <= ok_d;
      all_q <= all_d;
      idx_q <= idx_d;
    end
    if (exec_go) begin
      out_q <= res;
    end
  end

endmodule

### sv/multi_channel_stopwatch_bank_chk.sv
// Port-level checker for the stopwatch bank, bound to the top level.
module multi_channel_stopwatch_bank_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input msw_pkg::out_t             out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted during update");

  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a transaction");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.channel_valid |->
      out_data_o.returned_time == '0 && out_data_o.last_interval == '0 &&
      out_data_o.total_time == '0)
    else $error("invalid channel reported nonzero time");

endmodule

bind multi_channel_stopwatch_bank multi_channel_stopwatch_bank_chk u_chk (.*);

### tb/multi_channel_stopwatch_bank_test.sv
// Self-checking testbench for the multi-channel stopwatch bank.
`timescale 1ns / 100ps

module multi_channel_stopwatch_bank_test;
  import msw_pkg::*;

  localparam int unsigned MaxChannels = 16;
  localparam logic [ChanW-1:0] MaxCount = 5'd16;
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;
  localparam int unsigned PhaseItems = 140;
  localparam int unsigned LongHold = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit = 1000000;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_CMD,
    ROW_TYPED
  } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [ChanW-1:0] cfg_val;
    in_t              cmd;
    out_t             want;
  } tab_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic [ChanW-1:0] cfg_data_i;

  logic [ChanW-1:0] sw_count;
  logic [TimeW-1:0] sw_begin [MaxChannels];
  logic [TimeW-1:0] sw_span [MaxChannels];
  logic [TimeW-1:0] sw_total [MaxChannels];

  out_t pending_readings[$];
  tab_row_t dir_tab[$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_reqs = 0;
  bit send_idles = 1'b0;
  bit result_stalls = 1'b0;

  multi_channel_stopwatch_bank #(
    .MAX_CHANNELS(MaxChannels)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("multi_channel_stopwatch_bank test failed");
      $finish;
    end
  end

  function automatic void clear_bank(input logic [TimeW-1:0] ts);
    for (int k = 0; k < MaxChannels; k++) begin
      sw_begin[k] = ts;
      sw_span[k] = '0;
      sw_total[k] = '0;
    end
  endfunction

  function automatic out_t stopwatch_predict(input in_t cmd);
    out_t res;
    logic [ChanW-1:0] eff;
    logic hit;
    int unsigned idx;
    eff = (sw_count > MaxCount) ? MaxCount : sw_count;
    hit = cmd.channel < eff;
    idx = hit ? cmd.channel : 0;
    res = '0;
    case (cmd.operation)
      OP_START: begin
        if (hit) begin
          sw_begin[idx] = cmd.timestamp;
          res.returned_time = cmd.timestamp;
        end
      end
      OP_PAUSE, OP_PAUSE_RESTART: begin
        if (hit) begin
          sw_span[idx] = cmd.timestamp - sw_begin[idx];
          sw_total[idx] = sw_total[idx] + sw_span[idx];
          if (cmd.operation == OP_PAUSE_RESTART) sw_begin[idx] = cmd.timestamp;
          res.returned_time = cmd.timestamp;
        end
      end
      OP_RESET_ONE: begin
        if (hit) begin
          sw_span[idx] = '0;
          sw_total[idx] = '0;
          sw_begin[idx] = cmd.timestamp;
        end else if (cmd.channel == eff) begin
          clear_bank(cmd.timestamp);
        end
      end
      OP_RESET_ALL: begin
        clear_bank(cmd.timestamp);
      end
      default: ;
    endcase
    if (hit) begin
      res.last_interval = sw_span[idx];
      res.total_time = sw_total[idx];
      res.channel_valid = 1'b1;
    end
    return res;
  endfunction

  function automatic tab_row_t cmd_row(input row_kind_e kind, input logic [OpW-1:0] op,
                                       input logic [ChanW-1:0] ch, input logic [TimeW-1:0] ts,
                                       input logic [TimeW-1:0] rt, input logic [TimeW-1:0] li,
                                       input logic [TimeW-1:0] tt, input logic v);
    tab_row_t row;
    row.kind = kind;
    row.cfg_val = '0;
    row.cmd.operation = op;
    row.cmd.channel = ch;
    row.cmd.timestamp = ts;
    row.want.returned_time = rt;
    row.want.last_interval = li;
    row.want.total_time = tt;
    row.want.channel_valid = v;
    return row;
  endfunction

  function automatic tab_row_t cfg_row(input logic [ChanW-1:0] val);
    tab_row_t row;
    row = cmd_row(ROW_CFG, OP_QUERY, '0, '0, '0, '0, '0, 1'b0);
    row.cfg_val = val;
    return row;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [TimeW-1:0] got,
                                 input logic [TimeW-1:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic drain_readings();
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_cmd(input in_t cmd, input bit typed, input out_t typed_want);
    out_t predicted;
    in_data_i <= cmd;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = stopwatch_predict(cmd);
    pending_readings.push_back(typed ? typed_want : predicted);
  endtask

  task automatic idle_inputs(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [ChanW-1:0] val);
    in_valid_i <= 1'b0;
    drain_readings();
    cfg_we_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sw_count = val;
  endtask

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected transaction", out_data_o.returned_time, '0);
      end else begin
        want = pending_readings.pop_front();
        if (out_data_o.returned_time !== want.returned_time)
          report_mismatch("returned_time", out_data_o.returned_time, want.returned_time);
        if (out_data_o.last_interval !== want.last_interval)
          report_mismatch("last_interval", out_data_o.last_interval, want.last_interval);
        if (out_data_o.total_time !== want.total_time)
          report_mismatch("total_time", out_data_o.total_time, want.total_time);
        if (out_data_o.channel_valid !== want.channel_valid)
          report_mismatch("channel_valid", out_data_o.channel_valid, want.channel_valid);
      end
    end
  end

  initial begin : result_side
    int unsigned hold_seen;
    int unsigned gap;
    out_stall_i = 1'b0;
    hold_seen = 0;
    gap = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (gap != 0) begin
        gap--;
      end else if (result_stalls && $urandom_range(0, 99) < 20) begin
        gap = gap_len() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : command_side
    in_t cmd;
    int unsigned r;
    int unsigned eff;
    logic [ChanW-1:0] phase_count;
    logic [TimeW-1:0] now;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    sw_count = 5'd1;
    clear_bank('0);
    now = '0;

    dir_tab.push_back(cmd_row(ROW_TYPED, OP_QUERY, 5'd0, 64'd5, '0, '0, '0, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_QUERY, 5'd1, 64'd6, '0, '0, '0, 1'b0));
    dir_tab.push_back(cfg_row(5'd16));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_START, 5'd0, 64'd100, 64'd100, '0, '0, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_PAUSE, 5'd0, 64'd350, 64'd350, 64'd250, 64'd250,
                              1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_PAUSE_RESTART, 5'd0, 64'd400, 64'd400, 64'd300,
                              64'd550, 1'b1));
    // time running backwards wraps the interval
    dir_tab.push_back(cmd_row(ROW_CMD, OP_PAUSE, 5'd0, 64'd399, '0, '0, '0, 1'b0));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_START, 5'd15, '1, '1, '0, '0, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_PAUSE, 5'd15, '0, '0, 64'd1, 64'd1, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_START, 5'd16, 64'd123, '0, '0, '0, 1'b0));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_RESET_ONE, 5'd0, 64'd77, '0, '0, '0, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_RESET_ONE, 5'd16, 64'd1000, '0, '0, '0, 1'b0));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_QUERY, 5'd15, 64'd2000, '0, '0, '0, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_PAUSE, 5'd15, 64'd1500, 64'd1500, 64'd500,
                              64'd500, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_RESET_ALL, 5'd31, 64'd5, '0, '0, '0, 1'b0));
    dir_tab.push_back(cmd_row(ROW_TYPED, OpSpare6, 5'd3, 64'd9, '0, '0, '0, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OpSpare7, 5'd31, '1, '0, '0, '0, 1'b0));
    dir_tab.push_back(cmd_row(ROW_CMD, OP_PAUSE_RESTART, 5'd7, 64'h8000_0000_0000_0000,
                              '0, '0, '0, 1'b0));
    dir_tab.push_back(cfg_row(5'd0));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_START, 5'd0, 64'd1, '0, '0, '0, 1'b0));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_RESET_ONE, 5'd0, 64'd20, '0, '0, '0, 1'b0));
    dir_tab.push_back(cfg_row(5'd31));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_PAUSE, 5'd0, 64'd20, 64'd20, '0, '0, 1'b1));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_QUERY, 5'd15, 64'd21, '0, '0, '0, 1'b1));
    dir_tab.push_back(cfg_row(5'd5));
    dir_tab.push_back(cmd_row(ROW_TYPED, OP_RESET_ONE, 5'd5, 64'd3, '0, '0, '0, 1'b0));
    dir_tab.push_back(cmd_row(ROW_CMD, OP_PAUSE, 5'd4, 64'd10, '0, '0, '0, 1'b0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_count(dir_tab[i].cfg_val);
      else send_cmd(dir_tab[i].cmd, dir_tab[i].kind == ROW_TYPED, dir_tab[i].want);
    end

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: phase_count = 5'd16;
        1: phase_count = 5'd1;
        2: phase_count = 5'd0;
        3: phase_count = 5'd31;
        4: phase_count = 5'd17;
        5: phase_count = 5'd4;
        7: phase_count = ChanW'($urandom_range(1, 16));
        8: phase_count = 5'd8;
        default: phase_count = 5'd16;
      endcase
      write_count(phase_count);
      eff = (phase_count > MaxCount) ? MaxChannels : phase_count;
      send_idles = (p % 3 != 1);
      result_stalls = (p % 3 != 2);
      if (p == 5) begin
        // receiver sits on its results while commands keep coming
        send_idles = 1'b0;
        hold_reqs <= hold_reqs + 1;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 7 && i == PhaseItems / 2) begin
          in_valid_i <= 1'b0;
          drain_readings();
        end
        r = $urandom_range(0, 99);
        if (r < 22) cmd.operation = OP_START;
        else if (r < 44) cmd.operation = OP_PAUSE;
        else if (r < 64) cmd.operation = OP_PAUSE_RESTART;
        else if (r < 72) cmd.operation = OP_RESET_ONE;
        else if (r < 75) cmd.operation = OP_RESET_ALL;
        else if (r < 93) cmd.operation = OP_QUERY;
        else if (r < 96) cmd.operation = OpSpare6;
        else cmd.operation = OpSpare7;
        r = $urandom_range(0, 99);
        if (eff != 0 && r < 80) cmd.channel = ChanW'($urandom_range(0, eff - 1));
        else if (r < 88) cmd.channel = ChanW'(eff);
        else cmd.channel = ChanW'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 6) now = {$urandom, $urandom};
        else if (r < 9) now = '1 - $urandom_range(0, 3000);
        else if (r < 11) now = '0;
        else now = now + $urandom_range(0, 5000);
        cmd.timestamp = now;
        if (send_idles && $urandom_range(0, 99) < 30) idle_inputs(gap_len());
        send_cmd(cmd, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    drain_readings();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("multi_channel_stopwatch_bank test passed");
    end else begin
      $display("multi_channel_stopwatch_bank test failed");
    end
    $finish;
  end

endmodule

### files.f
sv/msw_pkg.sv
sv/msw_ram.sv
sv/msw_alu.sv
sv/multi_channel_stopwatch_bank.sv
sv/multi_channel_stopwatch_bank_chk.sv
tb/multi_channel_stopwatch_bank_test.sv
